[rtl/core/lrts_pkg.sv]
`timescale 1ns / 1ps

package lrts_pkg;

    // Width of the reported length field
    localparam int LENGTH_W = 24;

    // Record position and length counters (longest record is 259 bytes)
    localparam int POS_W = 9;

    // Type bytes at the head of each record
    localparam logic [7:0] TYPE_SHORT = 8'h01;
    localparam logic [7:0] TYPE_FIXED = 8'h02;
    localparam logic [7:0] TYPE_CODED = 8'h03;

    // Record sizes and the offsets of their length fields
    localparam logic [POS_W-1:0] SHORT_BASE   = 9'd4;
    localparam logic [POS_W-1:0] FIXED_SIZE   = 9'd19;
    localparam logic [POS_W-1:0] CODED_BASE   = 9'd14;
    localparam logic [POS_W-1:0] SHORT_LEN_AT = 9'd3;
    localparam logic [POS_W-1:0] CODED_DLC_AT = 9'd13;
    localparam logic [7:0]       DLC_MAX      = 8'd8;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_FIXED = 2'd2,
        KIND_CODED = 2'd3
    } kind_t;

endpackage

[rtl/core/log_record_tail_scanner.sv]
`timescale 1ns / 1ps

// Log record tail scanner.
// Input channel: data_valid / data_ready carry one word per buffer byte
// (data_byte) with final_byte high on the last byte of the buffer.
// Output channel: result_valid / result_ready carry one word per buffer,
// intact_length (bytes of complete records from the start) and
// garbage_found (bad type byte or data length code above 8 was met).
// Each byte sits in an input register while the record state is
// updated; the result of a final byte is loaded into the output
// register when that byte leaves the input register, and result_valid
// comes straight from that register.
// One byte is taken per cycle while no final byte is held back for a
// busy output register; the parse-and-commit path is combinational.
// While a result waits in the output register non-final bytes keep
// flowing, but the next final byte holds in the input register, with
// data_ready low, until the result is taken.
// Reset clears the record state and the valid flags of the input and
// output registers; the block is ready as soon as reset is released.
// A cut record at the end of a buffer is dropped without flagging it.
module log_record_tail_scanner
    import lrts_pkg::*;
#(
    parameter int LEN_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    output logic                data_ready,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [LENGTH_W-1:0] intact_length,
    output logic                garbage_found
);

    localparam int SUM_W = LEN_BITS + 2;
    localparam int EXT_W = (LEN_BITS > LENGTH_W) ? LEN_BITS : LENGTH_W;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Input register
    logic                 s1_valid_reg;
    logic [7:0]           s1_byte_reg;
    logic                 s1_final_reg;

    // Record state
    logic [LEN_BITS-1:0]  committed_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     need_reg;
    kind_t                kind_reg;
    logic                 stopped_reg;
    logic                 bad_reg;

    logic [LEN_BITS-1:0]  committed_next;
    logic [POS_W-1:0]     pos_next;
    logic [POS_W-1:0]     need_next;
    kind_t                kind_next;
    logic                 stopped_next;
    logic                 bad_next;

    // Output register
    logic                 result_valid_reg;
    logic [LENGTH_W-1:0]  length_reg;
    logic                 garbage_reg;
    logic                 result_valid_next;

    logic                 s1_advance;
    logic                 out_free;
    logic                 garbage_hit;
    logic [POS_W-1:0]     pos_inc;
    logic [SUM_W-1:0]     sum_wide;
    logic [EXT_W-1:0]     committed_ext;

    // Handshake: a final byte needs a free output register
    assign out_free   = !result_valid_reg || result_ready;
    assign s1_advance = s1_valid_reg && (!s1_final_reg || out_free);
    assign data_ready = !s1_valid_reg || s1_advance;

    // Parse one byte against the current record
    always_comb
    begin
        committed_next = committed_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        kind_next      = kind_reg;
        stopped_next   = stopped_reg;
        bad_next       = bad_reg;
        garbage_hit    = 1'b0;
        pos_inc        = pos_reg + 1'b1;
        sum_wide       = '0;
        if (!stopped_reg)
        begin
            if (pos_reg == '0)
            begin
                case (s1_byte_reg)
                    TYPE_SHORT:
                    begin
                        kind_next = KIND_SHORT;
                        need_next = SHORT_BASE;
                    end
                    TYPE_FIXED:
                    begin
                        kind_next = KIND_FIXED;
                        need_next = FIXED_SIZE;
                    end
                    TYPE_CODED:
                    begin
                        kind_next = KIND_CODED;
                        need_next = CODED_BASE;
                    end
                    default:
                    begin
                        garbage_hit = 1'b1;
                    end
                endcase
            end
            else if (kind_reg == KIND_SHORT && pos_reg == SHORT_LEN_AT)
            begin
                need_next = SHORT_BASE + {1'b0, s1_byte_reg};
            end
            else if (kind_reg == KIND_CODED && pos_reg == CODED_DLC_AT)
            begin
                if (s1_byte_reg > DLC_MAX)
                begin
                    garbage_hit = 1'b1;
                end
                else
                begin
                    need_next = CODED_BASE + {1'b0, s1_byte_reg};
                end
            end

            if (garbage_hit)
            begin
                stopped_next = 1'b1;
                bad_next     = 1'b1;
                need_next    = need_reg;
                kind_next    = kind_reg;
            end
            else if (pos_inc >= need_next)
            begin
                // Record complete: commit with saturation
                sum_wide = SUM_W'(committed_reg) + SUM_W'(need_next);
                if (sum_wide[SUM_W-1:LEN_BITS] != '0)
                begin
                    committed_next = LEN_MAX;
                end
                else
                begin
                    committed_next = sum_wide[LEN_BITS-1:0];
                end
                pos_next  = '0;
                need_next = '0;
                kind_next = KIND_NONE;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    assign committed_ext = EXT_W'(committed_next);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_advance && s1_final_reg)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (data_ready)
        begin
            s1_valid_reg <= data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            s1_byte_reg  <= data_byte;
            s1_final_reg <= final_byte;
        end
    end

    // Record state; cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= '0;
            pos_reg       <= '0;
            need_reg      <= '0;
            kind_reg      <= KIND_NONE;
            stopped_reg   <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else if (s1_advance)
        begin
            if (s1_final_reg)
            begin
                committed_reg <= '0;
                pos_reg       <= '0;
                need_reg      <= '0;
                kind_reg      <= KIND_NONE;
                stopped_reg   <= 1'b0;
                bad_reg       <= 1'b0;
            end
            else
            begin
                committed_reg <= committed_next;
                pos_reg       <= pos_next;
                need_reg      <= need_next;
                kind_reg      <= kind_next;
                stopped_reg   <= stopped_next;
                bad_reg       <= bad_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_final_reg)
        begin
            length_reg  <= committed_ext[LENGTH_W-1:0];
            garbage_reg <= bad_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign intact_length = length_reg;
    assign garbage_found = garbage_reg;

`ifndef SYNTHESIS
    // Garbage flag and stop flag always move together
    a_bad_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg == stopped_reg)
        else $error("garbage flag and stop flag disagree");

    // Inside a record the position stays below the record length
    a_pos_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == '0 || pos_reg < need_reg)
        else $error("record position reached record length");

    // A final byte leaves the record state cleared
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_final_reg |=>
            committed_reg == '0 && pos_reg == '0 && !stopped_reg)
        else $error("state not cleared after final byte");

    // Once stopped, bytes do not move the record position
    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && !(s1_advance && s1_final_reg) |=>
            stopped_reg && $stable(pos_reg) && $stable(committed_reg))
        else $error("stopped scan changed state");

    // A final byte held in the input register means the output is busy
    a_final_waits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_final_reg && !s1_advance |-> result_valid_reg)
        else $error("final byte stalled with free output register");
`endif

endmodule

[test/log_record_tail_scanner_tb.sv]
`timescale 1ns / 1ps

module log_record_tail_scanner_tb;
    import lrts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 400;

    // one word on the input channel, with an optional hand-typed answer
    typedef struct {
        logic [7:0]          data;
        logic                fin;
        logic                typed;
        logic [LENGTH_W-1:0] len;
        logic                garbage;
    } feed_word_t;

    typedef struct {
        logic [LENGTH_W-1:0] len;
        logic                garbage;
    } scan_result_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                data_valid    = 1'b0;
    logic                data_ready;
    logic [7:0]          data_byte     = 8'h00;
    logic                final_byte    = 1'b0;
    logic                result_valid;
    logic                result_ready  = 1'b0;
    logic [LENGTH_W-1:0] intact_length;
    logic                garbage_found;

    feed_word_t   byte_feed[$];
    scan_result_t awaited_results[$];
    logic [7:0]   rec_bytes[$];
    logic [7:0]   buf_bytes[$];

    feed_word_t   shown;
    scan_result_t want;

    // scanner copy kept by the testbench
    logic [LENGTH_W-1:0] run_len;
    logic [POS_W-1:0]    rec_pos;
    logic [POS_W-1:0]    rec_need;
    kind_t               rec_kind;
    logic                halted;
    logic                bad;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    bit hold_armed    = 0;
    bit hold_taken    = 0;
    int idle_cycles   = 0;
    int error_count   = 0;
    int bytes_taken   = 0;
    int buffers_seen  = 0;
    int garbage_seen  = 0;
    int queued_bytes  = 0;

    log_record_tail_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_ready    (data_ready),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .intact_length (intact_length),
        .garbage_found (garbage_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // clear the scanner copy to its post-reset values
    task clear_scan();
        run_len  = '0;
        rec_pos  = '0;
        rec_need = '0;
        rec_kind = KIND_NONE;
        halted   = 1'b0;
        bad      = 1'b0;
    endtask

    // advance the scanner copy by one accepted word
    task scan_word(input feed_word_t w);
        logic                skip;
        logic [LENGTH_W:0]   sum;
        scan_result_t        r;
        skip = 1'b0;
        if (!halted)
        begin
            if (rec_pos == '0)
            begin
                case (w.data)
                    TYPE_SHORT:
                    begin
                        rec_kind = KIND_SHORT;
                        rec_need = SHORT_BASE;
                    end
                    TYPE_FIXED:
                    begin
                        rec_kind = KIND_FIXED;
                        rec_need = FIXED_SIZE;
                    end
                    TYPE_CODED:
                    begin
                        rec_kind = KIND_CODED;
                        rec_need = CODED_BASE;
                    end
                    default:
                    begin
                        bad    = 1'b1;
                        halted = 1'b1;
                        skip   = 1'b1;
                    end
                endcase
            end
            else if (rec_kind == KIND_SHORT && rec_pos == SHORT_LEN_AT)
                rec_need = SHORT_BASE + {1'b0, w.data};
            else if (rec_kind == KIND_CODED && rec_pos == CODED_DLC_AT)
            begin
                if (w.data > DLC_MAX)
                begin
                    bad    = 1'b1;
                    halted = 1'b1;
                    skip   = 1'b1;
                end
                else
                    rec_need = CODED_BASE + {1'b0, w.data};
            end
            if (!skip)
            begin
                rec_pos = rec_pos + 1'b1;
                if (rec_pos >= rec_need)
                begin
                    // length saturates at all ones
                    sum      = {1'b0, run_len} + (LENGTH_W + 1)'(rec_need);
                    run_len  = sum[LENGTH_W] ? '1 : sum[LENGTH_W-1:0];
                    rec_pos  = '0;
                    rec_need = '0;
                    rec_kind = KIND_NONE;
                end
            end
        end
        if (w.fin)
        begin
            if (w.typed)
            begin
                r.len     = w.len;
                r.garbage = w.garbage;
            end
            else
            begin
                r.len     = run_len;
                r.garbage = bad;
            end
            awaited_results.push_back(r);
            clear_scan();
        end
    endtask

    task add_word(input logic [7:0] d, input logic f, input logic typed,
                  input int len, input logic g);
        feed_word_t w;
        w.data    = d;
        w.fin     = f;
        w.typed   = typed;
        w.len     = LENGTH_W'(len);
        w.garbage = g;
        byte_feed.push_back(w);
    endtask

    // one record of random kind and content into rec_bytes
    task make_record();
        int         sel;
        logic [7:0] code;
        rec_bytes.delete();
        sel = $urandom_range(2);
        if (sel == 0)
        begin
            code = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(12));
            rec_bytes.push_back(TYPE_SHORT);
            repeat (2) rec_bytes.push_back(8'($urandom_range(255)));
            rec_bytes.push_back(code);
            repeat (code) rec_bytes.push_back(8'($urandom_range(255)));
        end
        else if (sel == 1)
        begin
            rec_bytes.push_back(TYPE_FIXED);
            repeat (18) rec_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            // mostly a legal code, now and then one above the limit
            code = ($urandom_range(7) == 0) ? 8'($urandom_range(9, 255))
                                            : 8'($urandom_range(8));
            rec_bytes.push_back(TYPE_CODED);
            repeat (12) rec_bytes.push_back(8'($urandom_range(255)));
            rec_bytes.push_back(code);
            repeat ((code > DLC_MAX) ? $urandom_range(3) : code)
                rec_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // one whole buffer into the feed: noise, or records then a clean, cut or bad tail
    task queue_buffer();
        int         shape;
        int         cut;
        logic [7:0] b;
        buf_bytes.delete();
        shape = $urandom_range(9);
        if (shape < 3)
        begin
            // noise, with type-like values half the time
            repeat ($urandom_range(1, 8))
                buf_bytes.push_back($urandom_range(1) ? 8'($urandom_range(4))
                                                      : 8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                make_record();
                foreach (rec_bytes[i]) buf_bytes.push_back(rec_bytes[i]);
            end
            if (shape == 8)
            begin
                make_record();
                cut = $urandom_range(1, rec_bytes.size() - 1);
                for (int i = 0; i < cut; i++) buf_bytes.push_back(rec_bytes[i]);
            end
            else if (shape == 9)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == TYPE_SHORT || b == TYPE_FIXED || b == TYPE_CODED);
                buf_bytes.push_back(b);
                repeat ($urandom_range(5)) buf_bytes.push_back(8'($urandom_range(255)));
            end
        end
        foreach (buf_bytes[i])
            add_word(buf_bytes[i], i == buf_bytes.size() - 1, 1'b0, 0, 1'b0);
        queued_bytes += buf_bytes.size();
    endtask

    // sender stays quiet until every awaited result is back
    task wait_drained();
        while (byte_feed.size() != 0 || data_valid || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // input side: present the next word, feed the scanner copy on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (data_valid && data_ready)
            begin
                scan_word(shown);
                bytes_taken++;
            end
            if (!data_valid || data_ready)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    shown = byte_feed.pop_front();
                    data_valid <= 1'b1;
                    data_byte  <= shown.data;
                    final_byte <= shown.fin;
                end
                else
                    data_valid <= 1'b0;
            end
        end
    end

    // output side: check each word, random ready, one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                buffers_seen++;
                if (garbage_found === 1'b1)
                    garbage_seen++;
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: intact_length %0d garbage_found %0b",
                           intact_length, garbage_found);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (intact_length !== want.len)
                    begin
                        $error("intact_length: expected %0d, got %0d", want.len, intact_length);
                        error_count++;
                    end
                    if (garbage_found !== want.garbage)
                    begin
                        $error("garbage_found: expected %0b, got %0b",
                               want.garbage, garbage_found);
                        error_count++;
                    end
                end
            end
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: too long without any word moving
    always @(posedge clk)
    begin
        if ((data_valid && data_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clear_scan();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 15;
        recv_idle_pct = 60;

        // directed: cut record straight after reset
        add_word(TYPE_SHORT, 1'b1, 1'b1, 0, 1'b0);
        // bad type byte alone
        add_word(8'h00, 1'b1, 1'b1, 0, 1'b1);
        // shortest short record, extreme bytes inside
        add_word(TYPE_SHORT, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'hFF, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'h80, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'h00, 1'b1, 1'b1, 4, 1'b0);
        // record, bad type byte, then a byte that is ignored
        add_word(TYPE_SHORT, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'h00, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'h00, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'h00, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'h04, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'hFF, 1'b1, 1'b1, 4, 1'b1);
        // coded record with a code one above the limit
        add_word(TYPE_CODED, 1'b0, 1'b0, 0, 1'b0);
        for (int i = 0; i < 12; i++)
            add_word((i % 2) ? 8'h55 : 8'hAA, 1'b0, 1'b0, 0, 1'b0);
        add_word(8'h09, 1'b1, 1'b1, 0, 1'b1);

        queued_bytes = 0;
        while (queued_bytes < PHASE_BYTES) queue_buffer();
        wait_drained();

        // roles swapped
        send_idle_pct = 60;
        recv_idle_pct = 15;
        queued_bytes  = 0;
        while (queued_bytes < PHASE_BYTES) queue_buffer();
        wait_drained();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queued_bytes  = 0;
        while (queued_bytes < PHASE_BYTES) queue_buffer();
        wait_drained();

        // receiver holds off while short buffers pile up at the input
        hold_armed = 1'b1;
        while (!hold_taken) @(negedge clk);
        repeat (24) add_word(8'($urandom_range(255)), 1'b1, 1'b0, 0, 1'b0);
        repeat (4) queue_buffer();
        wait_drained();

        repeat (10) @(negedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            error_count++;
        end
        $display("Scanned %0d bytes across %0d buffers; %0d buffers reported garbage.",
                 bytes_taken, buffers_seen, garbage_seen);
        $display("Covered three idle patterns and one long output stall with input backpressure.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/core/lrts_pkg.sv
rtl/core/log_record_tail_scanner.sv
test/log_record_tail_scanner_tb.sv
